// ===== src/rmscm_pkg.sv =====
`timescale 1ns / 1ps

package rmscm_pkg;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [3:0]  plug;
		logic [11:0] sample;
		logic        sample_ok;
		logic        last_sample;
		logic [15:0] setting_value;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] current_ma;
		logic [15:0] offset_mv_q4;
		logic        calibrated;
		logic        reading_valid;
	} out_t;

	localparam logic [1:0] CMD_MEASURE    = 2'd0;
	localparam logic [1:0] CMD_CALIBRATE  = 2'd1;
	localparam logic [1:0] CMD_SET_OFFSET = 2'd2;
	localparam logic [1:0] CMD_SET_SENS   = 2'd3;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_BAD_PLUG   = 2'd1;
	localparam logic [1:0] STATUS_NO_SAMPLES = 2'd2;

	localparam logic [15:0] DEF_OFFSET_Q4  = 16'd40000;
	localparam logic [15:0] DEF_SENS_Q4    = 16'd2960;
	localparam logic [12:0] ADC_REF_RESET  = 13'd3300;
	localparam logic [11:0] ADC_FULL_SCALE = 12'd4095;
	localparam logic [12:0] MV_DIVISOR     = 13'd8190;
	localparam logic [9:0]  MILLI          = 10'd1000;

	// Millivolts in Q.4 fit 17 bits for any reference, the square of a
	// difference fits 34 bits, and the rounded voltage dividend fits 30 bits.
	localparam int MV_W      = 17;
	localparam int MV_DVD_W  = 30;
	localparam int DIFF_SQ_W = 34;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MV_MUL,
		ST_MV_DIV,
		ST_SQ_MUL,
		ST_CLOSE,
		ST_SUM_DIV,
		ST_SQRT,
		ST_CUR_MUL,
		ST_CUR_DIV,
		ST_CAL_MUL,
		ST_CAL_DIV,
		ST_DONE
	} state_t;

endpackage

// ===== src/rms_current_meter_with_zero_cal_core.sv =====
// True-RMS current meter for CHANNELS plugs with zero-offset calibration.
// Input beats (in_valid/in_ready, in_data) carry one ADC sample or one set
// command; output beats (out_valid/out_ready, out_data) carry one result.
// A sample beat that is not the last of its window produces no result.
// One item is worked on at a time. A good sample goes through a one-bit-per-
// cycle shift-add multiplier, a restoring divider and a second multiply that
// squares its offset difference; a set command goes straight to its result.
// Closing a measure window divides the sum by the count, takes the square
// root, then divides by the sensitivity; closing a calibration window
// multiplies the raw sum by the reference and divides by the count and the
// ADC full scale. The result is held in an output register, so a new input
// beat is taken while the previous result waits; if the receiver stalls for
// longer, the block holds its finished result and stops taking beats.
// Reset loads the default offsets and sensitivities, clears all flags and
// window sums, and sets the ADC reference to 3300 mV. cfg_we writes the
// reference at once; the user is to use it only while the block is idle,
// and the block itself does not enforce this.
`timescale 1ns / 1ps

module rms_current_meter_with_zero_cal_core import rmscm_pkg::*; #(
	parameter int CHANNELS   = 10,
	parameter int MAX_WINDOW = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data
);

	localparam int GCW    = $clog2(MAX_WINDOW + 1);
	localparam int IW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SQW    = DIFF_SQ_W + GCW;
	localparam int RSW    = 12 + GCW;
	localparam int DVW    = SQW + 8;
	localparam int QW     = DVW + (DVW % 2);
	localparam int RW     = QW / 2;
	localparam int DSW    = (GCW + 13 > 20) ? GCW + 13 : 20;
	localparam int CW     = $clog2(QW + 1);
	localparam int MBW    = MV_W;
	localparam int NCUR   = RW + 11;
	localparam int NCAL   = RSW + 19;
	localparam int SH_MV  = QW - MV_DVD_W;
	localparam int SH_SUM = QW - SQW;
	localparam int SH_CUR = QW - NCUR;
	localparam int SH_CAL = QW - NCAL;

	state_t state_q, state_d;

	logic [12:0]         ref_q;
	logic [15:0]         offset_q [CHANNELS];
	logic [15:0]         sens_q [CHANNELS];
	logic [CHANNELS-1:0] cal_flag_q;
	logic [CHANNELS-1:0] val_flag_q;
	logic [SQW-1:0]      sum_q;
	logic [RSW-1:0]      raw_q;
	logic [GCW-1:0]      gc_q;

	in_t            item_q;
	logic [QW-1:0]  mul_a_q;
	logic [QW-1:0]  mul_p_q;
	logic [MBW-1:0] mul_b_q;
	logic [DSW-1:0] div_r_q;
	logic [DSW-1:0] div_d_q;
	logic [QW-1:0]  div_q_q;
	logic [CW-1:0]  div_cnt_q;
	logic [RW:0]    sq_rem_q;
	logic [RW-1:0]  sq_root_q;
	logic           out_valid_q;
	out_t           out_q;

	logic           in_plug_ok, acc_ok, plug_ok, gc_zero;
	logic           mul_done, div_done, out_free;
	logic [IW-1:0]  idx;
	logic [15:0]    cur_off, cur_sens;
	logic [MV_W:0]  diff, abs_full;
	logic [MV_W-1:0] abs_diff;
	logic [DSW:0]   div_rem_sh, div_trial;
	logic           div_ge;
	logic [RW+2:0]  sq_rem_sh, sq_trial, sq_diff;
	logic           sq_ge;
	logic [QW-1:0]  dvd_mv, dvd_sum, dvd_cur, dvd_cal;
	logic [DSW-1:0] cal_den;
	logic [15:0]    q_sat;
	out_t           res_d;

	logic           fire, mul_step, div_step, sq_step, acc_en;
	logic           mul_ld, div_ld, sq_ld, cnt_ld;
	logic [QW-1:0]  mul_a_nx;
	logic [MBW-1:0] mul_b_nx;
	logic [QW-1:0]  div_dvd;
	logic [DSW-1:0] div_dsr;
	logic [CW-1:0]  cnt_nx;

	assign in_plug_ok = (in_data.plug != 4'd0) && (5'(in_data.plug) <= 5'(CHANNELS));
	assign acc_ok     = !in_data.cmd[1] && in_plug_ok && in_data.sample_ok
		&& (gc_q < GCW'(MAX_WINDOW));
	assign plug_ok    = (item_q.plug != 4'd0) && (5'(item_q.plug) <= 5'(CHANNELS));
	assign idx        = IW'(item_q.plug - 4'd1);
	assign cur_off    = offset_q[idx];
	assign cur_sens   = sens_q[idx];
	assign gc_zero    = (gc_q == '0);
	assign mul_done   = (mul_b_q == '0);
	assign div_done   = (div_cnt_q == '0);
	assign out_free   = !out_valid_q || out_ready;

	assign diff     = {1'b0, div_q_q[MV_W-1:0]} - (MV_W + 1)'(cur_off);
	assign abs_full = diff[MV_W] ? (~diff + 1'b1) : diff;
	assign abs_diff = abs_full[MV_W-1:0];

	assign div_rem_sh = {div_r_q, div_q_q[QW-1]};
	assign div_trial  = div_rem_sh - {1'b0, div_d_q};
	assign div_ge     = (div_rem_sh >= {1'b0, div_d_q});

	assign sq_rem_sh = {sq_rem_q, div_q_q[QW-1:QW-2]};
	assign sq_trial  = {1'b0, sq_root_q, 2'b01};
	assign sq_ge     = (sq_rem_sh >= sq_trial);
	assign sq_diff   = sq_rem_sh - sq_trial;

	assign cal_den = (DSW'(gc_q) << 12) - DSW'(gc_q);
	assign dvd_mv  = ((mul_p_q << 5) + QW'(ADC_FULL_SCALE)) << SH_MV;
	assign dvd_sum = QW'(sum_q) << SH_SUM;
	assign dvd_cur = (mul_p_q + (QW'(cur_sens) << 3)) << SH_CUR;
	assign dvd_cal = ((mul_p_q << 5) + QW'(cal_den)) << SH_CAL;
	assign q_sat   = (|div_q_q[QW-1:16]) ? 16'hFFFF : div_q_q[15:0];

	always_comb begin
		res_d.status        = STATUS_OK;
		res_d.current_ma    = '0;
		res_d.offset_mv_q4  = cur_off;
		res_d.calibrated    = cal_flag_q[idx];
		res_d.reading_valid = val_flag_q[idx];
		if (!plug_ok) begin
			res_d.status        = STATUS_BAD_PLUG;
			res_d.offset_mv_q4  = DEF_OFFSET_Q4;
			res_d.calibrated    = 1'b0;
			res_d.reading_valid = 1'b0;
		end else begin
			unique case (item_q.cmd)
				CMD_MEASURE: begin
					res_d.reading_valid = 1'b1;
					if (!gc_zero) begin
						if (cur_sens == '0) begin
							res_d.current_ma = (sq_root_q != '0) ? 16'hFFFF : 16'h0000;
						end else begin
							res_d.current_ma = q_sat;
						end
					end
				end
				CMD_CALIBRATE: begin
					if (gc_zero) begin
						res_d.status = STATUS_NO_SAMPLES;
					end else begin
						res_d.offset_mv_q4  = q_sat;
						res_d.calibrated    = 1'b1;
						res_d.reading_valid = 1'b1;
					end
				end
				CMD_SET_OFFSET: begin
					res_d.offset_mv_q4 = item_q.setting_value;
					res_d.calibrated   = 1'b1;
				end
				CMD_SET_SENS: begin
					res_d.offset_mv_q4 = cur_off;
				end
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_data.cmd[1]) begin
						state_d = ST_DONE;
					end else if (acc_ok) begin
						state_d = ST_MV_MUL;
					end else if (in_data.last_sample) begin
						state_d = ST_CLOSE;
					end
				end
			end
			ST_MV_MUL: if (mul_done) state_d = ST_MV_DIV;
			ST_MV_DIV: if (div_done) state_d = ST_SQ_MUL;
			ST_SQ_MUL: begin
				if (mul_done) begin
					state_d = item_q.last_sample ? ST_CLOSE : ST_IDLE;
				end
			end
			ST_CLOSE: begin
				if (!plug_ok || gc_zero) begin
					state_d = ST_DONE;
				end else if (item_q.cmd == CMD_MEASURE) begin
					state_d = ST_SUM_DIV;
				end else begin
					state_d = ST_CAL_MUL;
				end
			end
			ST_SUM_DIV: if (div_done) state_d = ST_SQRT;
			ST_SQRT: begin
				if (div_done) begin
					state_d = (cur_sens == '0) ? ST_DONE : ST_CUR_MUL;
				end
			end
			ST_CUR_MUL: if (mul_done) state_d = ST_CUR_DIV;
			ST_CUR_DIV: if (div_done) state_d = ST_DONE;
			ST_CAL_MUL: if (mul_done) state_d = ST_CAL_DIV;
			ST_CAL_DIV: if (div_done) state_d = ST_DONE;
			ST_DONE:    if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		fire     = 1'b0;
		mul_step = 1'b0;
		div_step = 1'b0;
		sq_step  = 1'b0;
		acc_en   = 1'b0;
		mul_ld   = 1'b0;
		div_ld   = 1'b0;
		sq_ld    = 1'b0;
		cnt_ld   = 1'b0;
		mul_a_nx = '0;
		mul_b_nx = '0;
		div_dvd  = '0;
		div_dsr  = '0;
		cnt_nx   = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && acc_ok) begin
					mul_ld   = 1'b1;
					mul_a_nx = QW'(ref_q);
					mul_b_nx = MBW'(in_data.sample);
				end
			end
			ST_MV_MUL: begin
				mul_step = !mul_done;
				if (mul_done) begin
					div_ld  = 1'b1;
					cnt_ld  = 1'b1;
					cnt_nx  = CW'(MV_DVD_W);
					div_dvd = dvd_mv;
					div_dsr = DSW'(MV_DIVISOR);
				end
			end
			ST_MV_DIV: begin
				div_step = !div_done;
				if (div_done) begin
					mul_ld   = 1'b1;
					mul_a_nx = QW'(abs_diff);
					mul_b_nx = abs_diff;
				end
			end
			ST_SQ_MUL: begin
				mul_step = !mul_done;
				acc_en   = mul_done;
			end
			ST_CLOSE: begin
				if (plug_ok && !gc_zero) begin
					if (item_q.cmd == CMD_MEASURE) begin
						div_ld  = 1'b1;
						cnt_ld  = 1'b1;
						cnt_nx  = CW'(DVW);
						div_dvd = dvd_sum;
						div_dsr = DSW'(gc_q);
					end else begin
						mul_ld   = 1'b1;
						mul_a_nx = QW'(raw_q);
						mul_b_nx = MBW'(ref_q);
					end
				end
			end
			ST_SUM_DIV: begin
				div_step = !div_done;
				if (div_done) begin
					sq_ld  = 1'b1;
					cnt_ld = 1'b1;
					cnt_nx = CW'(RW);
				end
			end
			ST_SQRT: begin
				sq_step = !div_done;
				if (div_done && cur_sens != '0) begin
					mul_ld   = 1'b1;
					mul_a_nx = QW'(sq_root_q);
					mul_b_nx = MBW'(MILLI);
				end
			end
			ST_CUR_MUL: begin
				mul_step = !mul_done;
				if (mul_done) begin
					div_ld  = 1'b1;
					cnt_ld  = 1'b1;
					cnt_nx  = CW'(NCUR);
					div_dvd = dvd_cur;
					div_dsr = DSW'(cur_sens) << 4;
				end
			end
			ST_CUR_DIV: div_step = !div_done;
			ST_CAL_MUL: begin
				mul_step = !mul_done;
				if (mul_done) begin
					div_ld  = 1'b1;
					cnt_ld  = 1'b1;
					cnt_nx  = CW'(NCAL);
					div_dvd = dvd_cal;
					div_dsr = cal_den << 1;
				end
			end
			ST_CAL_DIV: div_step = !div_done;
			ST_DONE:    fire = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ref_q       <= ADC_REF_RESET;
			out_valid_q <= 1'b0;
			cal_flag_q  <= '0;
			val_flag_q  <= '0;
			sum_q       <= '0;
			raw_q       <= '0;
			gc_q        <= '0;
			div_cnt_q   <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				offset_q[i] <= DEF_OFFSET_Q4;
				sens_q[i]   <= DEF_SENS_Q4;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				ref_q <= cfg_data;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cnt_ld) begin
				div_cnt_q <= cnt_nx;
			end else if (div_step || sq_step) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			if (acc_en) begin
				sum_q <= sum_q + SQW'(mul_p_q[DIFF_SQ_W-1:0]);
				raw_q <= raw_q + RSW'(item_q.sample);
				gc_q  <= gc_q + 1'b1;
			end
			if (fire && !item_q.cmd[1]) begin
				sum_q <= '0;
				raw_q <= '0;
				gc_q  <= '0;
			end
			if (fire && plug_ok) begin
				offset_q[idx]   <= res_d.offset_mv_q4;
				cal_flag_q[idx] <= res_d.calibrated;
				val_flag_q[idx] <= res_d.reading_valid;
				if (item_q.cmd == CMD_SET_SENS) begin
					sens_q[idx] <= item_q.setting_value;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_data;
		end
		if (mul_step) begin
			if (mul_b_q[0]) begin
				mul_p_q <= mul_p_q + mul_a_q;
			end
			mul_a_q <= mul_a_q << 1;
			mul_b_q <= mul_b_q >> 1;
		end
		if (mul_ld) begin
			mul_a_q <= mul_a_nx;
			mul_b_q <= mul_b_nx;
			mul_p_q <= '0;
		end
		if (div_step) begin
			div_r_q <= div_ge ? div_trial[DSW-1:0] : div_rem_sh[DSW-1:0];
			div_q_q <= {div_q_q[QW-2:0], div_ge};
		end
		if (div_ld) begin
			div_r_q <= '0;
			div_q_q <= div_dvd;
			div_d_q <= div_dsr;
		end
		if (sq_step) begin
			sq_rem_q  <= sq_ge ? sq_diff[RW:0] : sq_rem_sh[RW:0];
			sq_root_q <= {sq_root_q[RW-2:0], sq_ge};
			div_q_q   <= div_q_q << 2;
		end
		if (sq_ld) begin
			sq_rem_q  <= '0;
			sq_root_q <= '0;
		end
		if (fire) begin
			out_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_gc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		gc_q <= GCW'(MAX_WINDOW))
		else $error("Good-sample count exceeded the window limit.");

	a_cnt_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(div_cnt_q != '0) |-> (state_q == ST_MV_DIV || state_q == ST_SUM_DIV
			|| state_q == ST_SQRT || state_q == ST_CUR_DIV || state_q == ST_CAL_DIV))
		else $error("Step counter is running outside a divide or root state.");

	a_window_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !item_q.cmd[1]) |=> (gc_q == '0 && sum_q == '0 && raw_q == '0))
		else $error("Window sums were not cleared after a closing beat.");

	a_mv_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MV_DIV && div_done) |-> (div_q_q[QW-1:MV_W] == '0))
		else $error("Converted sample voltage overflowed its width.");

endmodule
